// ===== sv/bpsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpsa_pkg
// Shared widths, constants, types and the arctangent step table of the
// bilinear patch slope angle unit.
// ----------------------------------------------------------------------------
package bpsa_pkg;

    localparam int HEIGHT_W = 16;  // corner height
    localparam int DIFF_W   = 17;  // difference of two heights
    localparam int FRAC_W   = 17;  // Q0.16 position, one included
    localparam int PROD_W   = 35;  // signed 17 x signed 18 product
    localparam int MAG_W    = 32;  // magnitude of an interpolated difference
    localparam int SCALE_W  = 16;
    localparam int ANGLE_W  = 15;  // Q3.13
    localparam int XW       = 44;  // CORDIC x and y datapath
    localparam int ZW       = 33;  // CORDIC angle accumulator, Q2.30
    localparam int ATAN_LEN = 24;  // entries in the step table

    localparam logic [FRAC_W-1:0]  FRAC_ONE  = 17'd65536;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 15'd12868;  // pi/2 in Q3.13

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_vec_t;

    typedef struct packed {
        logic neg;   // height difference below zero
        logic zero;  // height difference exactly zero
    } angle_flags_t;

    typedef struct packed {
        cordic_vec_t  vx;
        cordic_vec_t  vy;
        angle_flags_t fx;
        angle_flags_t fy;
    } cordic_item_t;

    // atan(2^-i) in Q2.30, truncated
    function automatic logic [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic [ZW-1:0] v;
        begin
            case (idx)
                5'd0:    v = 33'd843314856;
                5'd1:    v = 33'd497837829;
                5'd2:    v = 33'd263043836;
                5'd3:    v = 33'd133525158;
                5'd4:    v = 33'd67021686;
                5'd5:    v = 33'd33543515;
                5'd6:    v = 33'd16775850;
                5'd7:    v = 33'd8388437;
                5'd8:    v = 33'd4194282;
                5'd9:    v = 33'd2097149;
                5'd10:   v = 33'd1048575;
                5'd11:   v = 33'd524287;
                5'd12:   v = 33'd262143;
                5'd13:   v = 33'd131071;
                5'd14:   v = 33'd65535;
                5'd15:   v = 33'd32767;
                5'd16:   v = 33'd16383;
                5'd17:   v = 33'd8191;
                5'd18:   v = 33'd4095;
                5'd19:   v = 33'd2047;
                5'd20:   v = 33'd1023;
                5'd21:   v = 33'd511;
                5'd22:   v = 33'd255;
                5'd23:   v = 33'd127;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== sv/bpsa_interp.sv =====
// ----------------------------------------------------------------------------
// bpsa_interp
// Front end: saturate the position, form corner differences and weights,
// multiply, sum, and set up both CORDIC vectors. Four register stages.
// ----------------------------------------------------------------------------
module bpsa_interp import bpsa_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [HEIGHT_W-1:0] height_bottom_left,
    input  logic signed [HEIGHT_W-1:0] height_bottom_right,
    input  logic signed [HEIGHT_W-1:0] height_top_left,
    input  logic signed [HEIGHT_W-1:0] height_top_right,
    input  logic        [FRAC_W-1:0]   frac_x,
    input  logic        [FRAC_W-1:0]   frac_y,
    input  logic        [SCALE_W-1:0]  scale,
    output logic                       out_valid,
    output cordic_item_t               out_item
);

    // stage 0: capture
    logic signed [HEIGHT_W-1:0] bl_reg, br_reg, tl_reg, tr_reg;
    logic        [FRAC_W-1:0]   fx_reg, fy_reg;
    logic                       v0_reg;

    // stage 1: differences and weights
    logic signed [DIFF_W-1:0] d_bot_reg, d_top_reg, d_left_reg, d_right_reg;
    logic        [FRAC_W-1:0] wx1_reg, wx0_reg, wy1_reg, wy0_reg;
    logic                     v1_reg;

    logic        [FRAC_W-1:0] fx_sat, fy_sat;

    // stage 2: products
    logic signed [PROD_W-1:0] p_bot_reg, p_top_reg, p_left_reg, p_right_reg;
    logic                     v2_reg;

    // stage 3: vector setup
    logic signed [PROD_W-1:0] num_x, num_y;
    logic        [MAG_W-1:0]  mag_x, mag_y;
    logic        [SCALE_W-1:0] scale_eff;
    cordic_item_t             item_next;
    cordic_item_t             item_reg;
    logic                     v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        bl_reg <= height_bottom_left;
        br_reg <= height_bottom_right;
        tl_reg <= height_top_left;
        tr_reg <= height_top_right;
        fx_reg <= frac_x;
        fy_reg <= frac_y;
    end

    // clip positions above one
    assign fx_sat = (fx_reg > FRAC_ONE) ? FRAC_ONE : fx_reg;
    assign fy_sat = (fy_reg > FRAC_ONE) ? FRAC_ONE : fy_reg;

    always_ff @(posedge clk)
    begin
        d_bot_reg   <= {br_reg[HEIGHT_W-1], br_reg} - {bl_reg[HEIGHT_W-1], bl_reg};
        d_top_reg   <= {tr_reg[HEIGHT_W-1], tr_reg} - {tl_reg[HEIGHT_W-1], tl_reg};
        d_left_reg  <= {tl_reg[HEIGHT_W-1], tl_reg} - {bl_reg[HEIGHT_W-1], bl_reg};
        d_right_reg <= {tr_reg[HEIGHT_W-1], tr_reg} - {br_reg[HEIGHT_W-1], br_reg};
        wx1_reg     <= fx_sat;
        wx0_reg     <= FRAC_ONE - fx_sat;
        wy1_reg     <= fy_sat;
        wy0_reg     <= FRAC_ONE - fy_sat;
    end

    always_ff @(posedge clk)
    begin
        p_bot_reg   <= d_bot_reg   * $signed({1'b0, wy0_reg});
        p_top_reg   <= d_top_reg   * $signed({1'b0, wy1_reg});
        p_left_reg  <= d_left_reg  * $signed({1'b0, wx0_reg});
        p_right_reg <= d_right_reg * $signed({1'b0, wx1_reg});
    end

    assign num_x     = p_bot_reg + p_top_reg;
    assign num_y     = p_left_reg + p_right_reg;
    assign mag_x     = num_x[PROD_W-1] ? MAG_W'(-num_x) : MAG_W'(num_x);
    assign mag_y     = num_y[PROD_W-1] ? MAG_W'(-num_y) : MAG_W'(num_y);
    assign scale_eff = (scale == '0) ? SCALE_W'(1) : scale;

    always_comb
    begin
        item_next.vx.x    = $signed({{(XW-SCALE_W-24){1'b0}}, scale_eff, 24'd0});
        item_next.vx.y    = $signed({{(XW-MAG_W-8){1'b0}}, mag_x, 8'd0});
        item_next.vx.z    = '0;
        item_next.vy.x    = $signed({{(XW-SCALE_W-24){1'b0}}, scale_eff, 24'd0});
        item_next.vy.y    = $signed({{(XW-MAG_W-8){1'b0}}, mag_y, 8'd0});
        item_next.vy.z    = '0;
        item_next.fx.neg  = num_x[PROD_W-1];
        item_next.fx.zero = (num_x == '0);
        item_next.fy.neg  = num_y[PROD_W-1];
        item_next.fy.zero = (num_y == '0);
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = v3_reg;
    assign out_item  = item_reg;

endmodule

// ===== sv/bpsa_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// bpsa_cordic_stage
// One registered vectoring step of the CORDIC, applied to both vectors.
// ----------------------------------------------------------------------------
module bpsa_cordic_stage import bpsa_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  cordic_item_t in_item,
    output logic         out_valid,
    output cordic_item_t out_item
);

    localparam logic [ZW-1:0] ATAN_STEP = atan_q30(SHIFT[4:0]);

    cordic_item_t item_next;
    cordic_item_t item_reg;
    logic         valid_reg;

    // rotate toward the x axis by atan(2^-SHIFT)
    function automatic cordic_vec_t rotate(input cordic_vec_t v);
        cordic_vec_t          r;
        logic signed [XW-1:0] xs, ys, dx, dy;
        begin
            xs = v.x;
            ys = v.y;
            dx = ys >>> SHIFT;
            dy = xs >>> SHIFT;
            if (!ys[XW-1])
            begin
                r.x = xs + dx;
                r.y = ys - dy;
                r.z = v.z + $signed(ATAN_STEP);
            end
            else
            begin
                r.x = xs - dx;
                r.y = ys + dy;
                r.z = v.z - $signed(ATAN_STEP);
            end
            return r;
        end
    endfunction

    always_comb
    begin
        item_next    = in_item;
        item_next.vx = rotate(in_item.vx);
        item_next.vy = rotate(in_item.vy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== sv/bpsa_finish.sv =====
// ----------------------------------------------------------------------------
// bpsa_finish
// Round the accumulated angles to Q3.13, clamp to pi/2, apply the sign and
// register the result with its strobe.
// ----------------------------------------------------------------------------
module bpsa_finish import bpsa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  cordic_item_t              in_item,
    output logic                      done,
    output logic signed [ANGLE_W-1:0] angle_x,
    output logic signed [ANGLE_W-1:0] angle_y
);

    logic                      done_reg;
    logic signed [ANGLE_W-1:0] angle_x_reg, angle_y_reg;

    function automatic logic [ANGLE_W-1:0] finish_angle(
        input logic [ZW-1:0] z,
        input angle_flags_t  f
    );
        logic [ZW-1:0]      zc;
        logic [ZW-1:0]      sum;
        logic [ANGLE_W-1:0] r;
        begin
            zc  = z[ZW-1] ? '0 : z;
            sum = zc + ZW'(1 << 16);
            r   = sum[17 +: ANGLE_W];
            if (r > ANGLE_MAX)
                r = ANGLE_MAX;
            if (f.zero)
                r = '0;
            else if (f.neg)
                r = -r;
            return r;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        angle_x_reg <= $signed(finish_angle(in_item.vx.z, in_item.fx));
        angle_y_reg <= $signed(finish_angle(in_item.vy.z, in_item.fy));
    end

    assign done    = done_reg;
    assign angle_x = angle_x_reg;
    assign angle_y = angle_y_reg;

endmodule

// ===== sv/bilinear_patch_slope_angles_unit.sv =====
// ----------------------------------------------------------------------------
// bilinear_patch_slope_angles_unit
// Tilt angles along x and y of a bilinear height patch at a point inside it.
// ----------------------------------------------------------------------------
// Usage:
//   Present the four corner heights and the position with start high; the
//   item is taken at a rising edge where start is high and busy is low.
//   busy is high only in the first cycle out of reset, so afterwards an item
//   can be taken every cycle: the unit is a fully pipelined datapath.
//   Each result appears on angle_x / angle_y for exactly one cycle with done
//   high. The path from an accepted item to its result is four front-end
//   stages (capture, differences, multiply, vector setup), one stage per
//   CORDIC step (iterations capped at 24) and one rounding stage. Results
//   leave in the order items entered.
//   The receiver cannot hold results off; none is needed since nothing waits.
//   cell_scale is written over cfg_valid / cfg_ready / cfg_data, always
//   ready; write it only while no item is in flight. A scale of zero acts
//   as one. Reset clears all valid bits and sets cell_scale to one.
// ----------------------------------------------------------------------------
module bilinear_patch_slope_angles_unit import bpsa_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [HEIGHT_W-1:0] height_bottom_left,
    input  logic signed [HEIGHT_W-1:0] height_bottom_right,
    input  logic signed [HEIGHT_W-1:0] height_top_left,
    input  logic signed [HEIGHT_W-1:0] height_top_right,
    input  logic        [FRAC_W-1:0]   frac_x,
    input  logic        [FRAC_W-1:0]   frac_y,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic        [SCALE_W-1:0]  cfg_data,
    output logic                       done,
    output logic signed [ANGLE_W-1:0]  angle_x,
    output logic signed [ANGLE_W-1:0]  angle_y
);

    // steps past the end of the table are not taken
    localparam int NUM_ITER = (ANGLE_ITERATIONS < ATAN_LEN) ? ANGLE_ITERATIONS : ATAN_LEN;
    localparam int LATENCY  = NUM_ITER + 5;

    logic               busy_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               accept;

    logic               stage_valid [NUM_ITER+1];
    cordic_item_t       stage_item  [NUM_ITER+1];

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;

    // hold busy for the first cycle after reset, then release for good
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_W'(1);
        else if (cfg_valid && cfg_ready)
            scale_reg <= cfg_data;
    end

    // front end: interpolated edge differences and CORDIC setup
    bpsa_interp u_interp
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (accept),
        .height_bottom_left  (height_bottom_left),
        .height_bottom_right (height_bottom_right),
        .height_top_left     (height_top_left),
        .height_top_right    (height_top_right),
        .frac_x              (frac_x),
        .frac_y              (frac_y),
        .scale               (scale_reg),
        .out_valid           (stage_valid[0]),
        .out_item            (stage_item[0])
    );

    // one registered CORDIC step per stage; both angles advance together
    for (genvar i = 0; i < NUM_ITER; i++)
    begin : g_cordic
        bpsa_cordic_stage #(.SHIFT(i)) u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_item   (stage_item[i]),
            .out_valid (stage_valid[i+1]),
            .out_item  (stage_item[i+1])
        );
    end

    // round, clamp, apply sign, drive the strobe
    bpsa_finish u_finish
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stage_valid[NUM_ITER]),
        .in_item  (stage_item[NUM_ITER]),
        .done     (done),
        .angle_x  (angle_x),
        .angle_y  (angle_y)
    );

    // every accepted item yields exactly one result after the fixed latency
    a_item_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted item produced no result at expected latency");

    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without a matching accepted item");

    a_angle_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (angle_x <= $signed(ANGLE_MAX)) && (angle_x >= -$signed(ANGLE_MAX)))
        else $error("angle_x outside +/- pi/2");

    a_angle_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (angle_y <= $signed(ANGLE_MAX)) && (angle_y >= -$signed(ANGLE_MAX)))
        else $error("angle_y outside +/- pi/2");

endmodule
